// ----- hw/rtl/lis_pkg.sv -----
// Shared constants and types for the longest increasing subsequence block.
package lis_pkg;

	localparam int VALUE_W         = 17;
	localparam int LENGTH_W        = 10;
	localparam int MAX_LEN_DEFAULT = 512;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_FIN
	} lis_state_t;

endpackage

// ----- hw/rtl/lis_step.sv -----
// One binary-search step: opens the [lo, hi) window on start, else narrows it, and picks the next probe.
module lis_step #(
	parameter int CNT_W = 10,
	parameter int IDX_W = 9
) (
	input  logic                       start,
	input  logic [CNT_W-1:0]           run_len,
	input  logic [CNT_W-1:0]           lo,
	input  logic [CNT_W-1:0]           hi,
	input  logic [IDX_W-1:0]           mid,
	input  logic [lis_pkg::VALUE_W-1:0] probe,
	input  logic [lis_pkg::VALUE_W-1:0] key,
	output logic [CNT_W-1:0]           lo_n,
	output logic [CNT_W-1:0]           hi_n,
	output logic [IDX_W-1:0]           mid_n,
	output logic                       more
);
	import lis_pkg::*;

	logic [CNT_W:0] sum;

	always_comb begin
		if (start) begin
			lo_n = '0;
			hi_n = run_len;
		end else if (probe < key) begin
			lo_n = CNT_W'(mid) + CNT_W'(1);
			hi_n = hi;
		end else begin
			lo_n = lo;
			hi_n = CNT_W'(mid);
		end
		more  = lo_n < hi_n;
		sum   = {1'b0, lo_n} + {1'b0, hi_n};
		mid_n = IDX_W'(sum >> 1);
	end

endmodule

// ----- hw/rtl/longest_increasing_subsequence.sv -----
// Top level: streaming longest strictly increasing subsequence length.
//
//  channel | signals                      | dir | item
//  --------+------------------------------+-----+------------------------------
//  in      | in_valid in_ready value last | in  | one sequence element
//  out     | out_valid out_ready          | out | length, overflow per sequence
//          | length overflow              |     |
//
// An element is taken in IDLE, where the search window is opened, then makes one
// binary-search probe of the tail store per step: up to ceil(log2(n+1)) probes
// for n stored tails, 10 at a full store of 512. The tail memory has one registered
// read port, read once per probe. An element with last set then passes through FIN
// to load the result register, and waits there while an earlier result is still not taken.
// Reset clears the count, the drop flag and the result valid flag; the tail store
// needs no clearing since only entries below the count are ever read.
module longest_increasing_subsequence #(
	parameter int MAX_LEN = lis_pkg::MAX_LEN_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [lis_pkg::VALUE_W-1:0]  value,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lis_pkg::LENGTH_W-1:0] length,
	output logic                         overflow
);
	import lis_pkg::*;

	localparam int CNT_W = $clog2(MAX_LEN + 1);
	localparam int IDX_W = $clog2(MAX_LEN);

	// smallest tail value for each subsequence length
	logic [VALUE_W-1:0] tails [MAX_LEN];

	lis_state_t state_q, state_d;

	logic [VALUE_W-1:0]  value_q;
	logic                last_q;
	logic [CNT_W-1:0]    lo_q, hi_q;
	logic [IDX_W-1:0]    mid_q;
	logic [CNT_W-1:0]    run_len_q;
	logic                dropped_q;
	logic [VALUE_W-1:0]  rdata_q;
	logic                out_valid_q;
	logic [LENGTH_W-1:0] length_q;
	logic                overflow_q;

	logic [VALUE_W-1:0]  cur_key;
	logic                cur_last;
	logic [CNT_W-1:0]    lo_n, hi_n;
	logic [IDX_W-1:0]    mid_n;
	logic                more;
	logic                step_en;
	logic                mem_re, mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic                run_inc, drop_set, load_out;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign length    = length_q;
	assign overflow  = overflow_q;

	// in IDLE the step works straight off the input port
	assign cur_key  = (state_q == S_IDLE) ? value : value_q;
	assign cur_last = (state_q == S_IDLE) ? last : last_q;

	lis_step #(
		.CNT_W(CNT_W),
		.IDX_W(IDX_W)
	) u_step (
		.start  (state_q == S_IDLE),
		.run_len(run_len_q),
		.lo     (lo_q),
		.hi     (hi_q),
		.mid    (mid_q),
		.probe  (rdata_q),
		.key    (cur_key),
		.lo_n   (lo_n),
		.hi_n   (hi_n),
		.mid_n  (mid_n),
		.more   (more)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		step_en   = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		run_inc   = 1'b0;
		drop_set  = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE:   step_en = in_valid;
			S_SEARCH: step_en = 1'b1;
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
		if (step_en) begin
			if (more) begin
				mem_re  = 1'b1;
				state_d = S_SEARCH;
			end else begin
				// search settled: lo_n is the first tail >= key
				if (lo_n < run_len_q) begin
					mem_we    = 1'b1;
					mem_waddr = IDX_W'(lo_n);
				end else if (run_len_q < CNT_W'(MAX_LEN)) begin
					mem_we    = 1'b1;
					mem_waddr = IDX_W'(run_len_q);
					run_inc   = 1'b1;
				end else begin
					drop_set = 1'b1;
				end
				state_d = cur_last ? S_FIN : S_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len_q   <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				run_len_q <= '0;
				dropped_q <= 1'b0;
			end else begin
				if (run_inc) begin
					run_len_q <= run_len_q + CNT_W'(1);
				end
				if (drop_set) begin
					dropped_q <= 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			value_q <= value;
			last_q  <= last;
		end
		if (step_en) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
		if (load_out) begin
			length_q   <= LENGTH_W'(run_len_q);
			overflow_q <= dropped_q;
		end
	end

	// tail store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tails[mem_waddr] <= cur_key;
		end
		if (mem_re) begin
			rdata_q <= tails[mid_n];
		end
	end

endmodule

// ----- hw/rtl/lis_checker.sv -----
// Port-level checks for the longest increasing subsequence block, with bind.
module lis_checker #(
	parameter int MAX_LEN = lis_pkg::MAX_LEN_DEFAULT
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         last,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [lis_pkg::LENGTH_W-1:0] length,
	input logic                         overflow
);
	import lis_pkg::*;

	// a waiting result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(length) && $stable(overflow))
		else $error("result changed while stalled");

	// in_ready is low right after a final item is taken
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> !in_ready)
		else $error("ready right after accepting a final item");

	// a drop only happens with a full store
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> length == LENGTH_W'(MAX_LEN))
		else $error("overflow reported below full length");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind longest_increasing_subsequence lis_checker #(.MAX_LEN(MAX_LEN)) u_lis_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.last     (last),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.length   (length),
	.overflow (overflow)
);
